// File: sv/cdq_pkg.sv
// Shared types and constants for the circular deque.
package cdq_pkg;

   localparam int SLOTS  = 1024;
   localparam int IDX_W  = $clog2(SLOTS);
   localparam int DATA_W = 32;
   localparam int CAP_W  = 10;

   typedef enum logic [1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_POP_FRONT  = 2'd1,
      OP_PUSH_BACK  = 2'd2,
      OP_POP_BACK   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_RESP = 3'b100
   } state_type;

   typedef struct packed {
      logic load;
      logic exec;
   } cmd_type;

endpackage

// File: sv/cdq_ctrl.sv
// Sequencer for the circular deque: accept, execute, deliver.
module cdq_ctrl
   import cdq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RESP);
   assign cmd.load   = req_tvalid && req_tready;
   assign cmd.exec   = (state_ff == S_EXEC);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: sv/cdq_dp.sv
// Datapath for the circular deque: indices, ring memory and result registers.
module cdq_dp
   import cdq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   input  logic              csr_we,
   input  logic [CAP_W-1:0]  csr_wdata,
   input  logic [1:0]        req_op,
   input  logic [DATA_W-1:0] req_value,
   output logic [1:0]        rsp_status,
   output logic [DATA_W-1:0] rsp_value
);

   logic [DATA_W-1:0] ring_mem [SLOTS];

   logic [CAP_W-1:0]  capacity_ff;
   logic [IDX_W-1:0]  front_ff, front_in;
   logic [IDX_W-1:0]  rear_ff, rear_in;
   op_type            op_ff;
   logic [DATA_W-1:0] value_ff;
   status_type        status_ff, status_in;
   logic              pop_ok_ff, pop_ok_in;
   logic [DATA_W-1:0] rd_ff;

   logic [IDX_W-1:0]  last_idx;
   logic [IDX_W-1:0]  front_fwd, front_back, rear_fwd, rear_back;
   logic [IDX_W-1:0]  waddr, raddr;
   logic              we;

   assign last_idx = (int'(capacity_ff) >= SLOTS - 1) ? IDX_W'(SLOTS - 1)
                                                       : IDX_W'(capacity_ff);

   assign front_fwd  = (front_ff == last_idx) ? '0 : front_ff + 1'b1;
   assign front_back = (front_ff == '0) ? last_idx : front_ff - 1'b1;
   assign rear_fwd   = (rear_ff == last_idx) ? '0 : rear_ff + 1'b1;
   assign rear_back  = (rear_ff == '0) ? last_idx : rear_ff - 1'b1;

   always_comb begin
      front_in  = front_ff;
      rear_in   = rear_ff;
      status_in = ST_DONE;
      pop_ok_in = 1'b0;
      we        = 1'b0;
      waddr     = rear_ff;
      raddr     = front_ff;
      case (op_ff)
         OP_PUSH_FRONT: begin
            waddr = front_back;
            if (front_back == rear_ff) begin
               status_in = ST_FULL;
            end else begin
               front_in = front_back;
               we       = 1'b1;
            end
         end
         OP_POP_FRONT: begin
            raddr = front_ff;
            if (front_ff == rear_ff) begin
               status_in = ST_EMPTY;
            end else begin
               front_in  = front_fwd;
               pop_ok_in = 1'b1;
            end
         end
         OP_PUSH_BACK: begin
            waddr = rear_ff;
            if (rear_fwd == front_ff) begin
               status_in = ST_FULL;
            end else begin
               rear_in = rear_fwd;
               we      = 1'b1;
            end
         end
         OP_POP_BACK: begin
            raddr = rear_back;
            if (front_ff == rear_ff) begin
               status_in = ST_EMPTY;
            end else begin
               rear_in   = rear_back;
               pop_ok_in = 1'b1;
            end
         end
         default: begin
            status_in = ST_DONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_W'(1023);
         front_ff    <= '0;
         rear_ff     <= '0;
      end else if (csr_we) begin
         capacity_ff <= csr_wdata;
         front_ff    <= '0;
         rear_ff     <= '0;
      end else if (cmd.exec) begin
         front_ff <= front_in;
         rear_ff  <= rear_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= op_type'(req_op);
         value_ff <= req_value;
      end
      if (cmd.exec) begin
         status_ff <= status_in;
         pop_ok_ff <= pop_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && we) begin
         ring_mem[waddr] <= value_ff;
      end
      if (cmd.exec) begin
         rd_ff <= ring_mem[raddr];
      end
   end

   assign rsp_status = status_ff;
   assign rsp_value  = pop_ok_ff ? rd_ff : '0;

`ifndef SYNTHESIS
   a_index_in_ring: assert property (@(posedge clock) disable iff (reset)
      front_ff <= last_idx && rear_ff <= last_idx)
      else $error("deque index beyond ring");

   a_success_moves_index: assert property (@(posedge clock) disable iff (reset)
      cmd.exec && !csr_we && status_in == ST_DONE |=>
         front_ff != $past(front_ff) || rear_ff != $past(rear_ff))
      else $error("successful transfer left indices unchanged");

   a_pop_ok_done: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> !pop_ok_ff || status_ff == ST_DONE)
      else $error("pop data flagged on refused transfer");
`endif

endmodule

// File: sv/circular_deque.sv
// Top level of the circular deque: sequencer plus datapath.
// Double-ended queue over a ring of capacity+1 slots (at most 1024). Each
// request transfer carries an operation in req_tuser and a value in req_tdata;
// each yields exactly one response with a status in rsp_tuser and the popped
// value (zero otherwise) in rsp_tdata. An operation passes through accept,
// one ring-memory access with a registered read, and result: the response
// is valid in the result state, which follows the execute state, and stays
// valid until rsp_tready; a new request is accepted only after the response
// transfer. Writing the capacity register empties the deque; write it only
// while no transfer is in flight.
module circular_deque
   import cdq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [31:0]       req_tdata,  // [31:0] value_in
   input  logic [1:0]        req_tuser,  // [1:0] operation
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [31:0]       rsp_tdata,  // [31:0] value_out
   output logic [1:0]        rsp_tuser,  // [1:0] status
   input  logic              csr_we,
   input  logic [CAP_W-1:0]  csr_wdata
);

   cmd_type cmd;

   cdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   cdq_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_op     (req_tuser),
      .req_value  (req_tdata),
      .rsp_status (rsp_tuser),
      .rsp_value  (rsp_tdata)
   );

endmodule
